[sv/positional_list_insert_erase_assert.svh]
`ifndef POSITIONAL_LIST_INSERT_ERASE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_ERASE_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define PLIE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("positional list check failed");

// Next-cycle implication, held off while reset is high.
`define PLIE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("positional list check failed");

`endif

[sv/plie_pkg.sv]
package plie_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ERASE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         first_position;
    logic [5:0]         last_position;
    logic signed [31:0] new_value;
  } plie_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         removed_count;
    logic [6:0]         list_length;
  } plie_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic init_idx;
    logic step;
    logic mem_rd;
    logic mem_wr;
    logic put;
    logic finish;
  } plie_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       full;
    logic       erase_ok;
    logic       read_ok;
    logic       more;
  } plie_stat_t;

endpackage

[sv/positional_list_insert_erase.sv]
// Ordered list of up to CAPACITY signed 32-bit values addressed by position,
// with insert-before, inclusive range erase and read. A command beat is taken
// when start is high and busy is low; its single result shows on result for
// exactly one cycle with done high, and the receiver cannot stall it, so take
// it in that cycle. The list lives in a single-port-style memory with one
// write and one registered read per cycle, so elements move one at a time,
// read in LOOP and written in MOVE_WR. Insert shifts up the elements from
// the position (clamped to length) on, then writes the new value; erase
// shifts down those behind the range; read and refused commands move none.
// Done follows in the cycle after the last busy cycle. A new command may be
// started in the cycle done is shown. No clearing pass is needed after reset.
module positional_list_insert_erase import plie_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  plie_in_t  item,
  output plie_out_t result,
  output logic      done
);

  plie_ctrl_t ctrl;
  plie_stat_t stat;

  plie_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  plie_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

endmodule

[sv/plie_ctrl.sv]
module plie_ctrl import plie_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  plie_stat_t stat,
  output plie_ctrl_t ctrl,
  output logic       busy
);

  typedef enum logic [4:0] {
    IDLE    = 5'b00001,
    DECODE  = 5'b00010,
    LOOP    = 5'b00100,
    MOVE_WR = 5'b01000,
    RD_WAIT = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      IDLE: begin
        if (start) begin
          ctrl.load  = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        case (stat.command)
          CMD_INSERT: begin
            if (stat.full) begin
              ctrl.finish = 1'b1;
              state_next  = IDLE;
            end else begin
              ctrl.init_idx = 1'b1;
              state_next    = LOOP;
            end
          end
          CMD_ERASE: begin
            if (stat.erase_ok) begin
              ctrl.init_idx = 1'b1;
              state_next    = LOOP;
            end else begin
              ctrl.finish = 1'b1;
              state_next  = IDLE;
            end
          end
          CMD_READ: begin
            if (stat.read_ok) begin
              ctrl.mem_rd = 1'b1;
              state_next  = RD_WAIT;
            end else begin
              ctrl.finish = 1'b1;
              state_next  = IDLE;
            end
          end
          default: begin
            ctrl.finish = 1'b1;
            state_next  = IDLE;
          end
        endcase
      end
      LOOP: begin
        if (stat.more) begin
          ctrl.mem_rd = 1'b1;
          state_next  = MOVE_WR;
        end else begin
          // shifting is over: drop the new value into its slot on insert
          ctrl.put    = (stat.command == CMD_INSERT);
          ctrl.finish = 1'b1;
          state_next  = IDLE;
        end
      end
      MOVE_WR: begin
        ctrl.mem_wr = 1'b1;
        ctrl.step   = 1'b1;
        state_next  = LOOP;
      end
      RD_WAIT: begin
        ctrl.finish = 1'b1;
        state_next  = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign busy = (state != IDLE);

endmodule

[sv/plie_dp.sv]
module plie_dp import plie_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  plie_in_t   item,
  input  plie_ctrl_t ctrl,
  output plie_stat_t stat,
  output plie_out_t  result,
  output logic       done
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rdata;

  plie_in_t        cur;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [PW-1:0]   idx;

  logic [PW-1:0]   first_w, last_w, count_w, pos_w, end_w, removed_w, src_w;
  logic            is_ins, is_era, is_rd;
  logic [AW-1:0]   raddr, waddr;
  logic signed [31:0] wdata;

  assign is_ins  = (cur.command == CMD_INSERT);
  assign is_era  = (cur.command == CMD_ERASE);
  assign is_rd   = (cur.command == CMD_READ);
  assign first_w = PW'(cur.first_position);
  assign last_w  = PW'(cur.last_position);
  assign count_w = PW'(count);

  assign pos_w     = (first_w < count_w) ? first_w : count_w;
  assign end_w     = (last_w < count_w) ? last_w : (count_w - PW'(1));
  assign removed_w = end_w - first_w + PW'(1);

  assign stat.command  = cur.command;
  assign stat.full     = (count_w >= PW'(CAPACITY));
  assign stat.read_ok  = (first_w < count_w);
  assign stat.erase_ok = (count_w != '0) && (first_w <= last_w) && (first_w < count_w);
  assign stat.more     = is_ins ? (idx > pos_w) : ((idx + removed_w) < count_w);

  // source of a move beat: one below on insert, one range above on erase
  assign src_w = is_rd ? first_w : (is_ins ? (idx - PW'(1)) : (idx + removed_w));
  assign raddr = src_w[AW-1:0];
  assign waddr = ctrl.put ? pos_w[AW-1:0] : idx[AW-1:0];
  assign wdata = ctrl.put ? cur.new_value : rdata;

  always_ff @(posedge clk) begin
    if (ctrl.mem_rd) begin
      rdata <= mem[raddr];
    end
    if (ctrl.mem_wr || ctrl.put) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cur <= item;
    end
    if (ctrl.init_idx) begin
      idx <= is_ins ? count_w : first_w;
    end else if (ctrl.step) begin
      idx <= is_ins ? (idx - PW'(1)) : (idx + PW'(1));
    end
  end

  always_comb begin
    count_next = count;
    if (ctrl.finish) begin
      if (is_ins && !stat.full) begin
        count_next = count + CW'(1);
      end else if (is_era && stat.erase_ok) begin
        count_next = count - removed_w[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      result.read_value    <= (is_rd && stat.read_ok) ? rdata : 32'sd0;
      result.removed_count <= (is_era && stat.erase_ok) ? 7'(removed_w) : 7'd0;
      result.list_length   <= 7'(count_next);
      if (is_ins && stat.full) begin
        result.status <= ST_FULL;
      end else if (is_rd && !stat.read_ok) begin
        result.status <= ST_RANGE;
      end else begin
        result.status <= ST_DONE;
      end
    end
  end

endmodule

[sv/plie_checker.sv]
`include "positional_list_insert_erase_assert.svh"

module plie_checker import plie_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input plie_out_t result,
  input logic      done
);

  // an accepted beat makes the block busy in the next cycle
  `PLIE_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)

  // a result only ever follows a busy cycle
  `PLIE_ASSERT_NEXT(a_idle_no_done, clk, rst, !busy, !done)

  // a failed command returns no value
  `PLIE_ASSERT_NOW(a_fail_zero, clk, rst, done && (result.status != ST_DONE),
                   result.read_value == 32'sd0)

  // removal only happens on a clean erase, which reads nothing
  `PLIE_ASSERT_NOW(a_removed_clean, clk, rst, done && (result.removed_count != 7'd0),
                   (result.status == ST_DONE) && (result.read_value == 32'sd0))

endmodule

bind positional_list_insert_erase plie_checker u_plie_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .result (result),
  .done   (done)
);
